/* src/stable_priority_queue_ten_levels_core_macros.svh */
// assertion macros for the stable priority queue core
`ifndef STABLE_PRIORITY_QUEUE_TEN_LEVELS_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TEN_LEVELS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SPQ_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

/* src/spq_pkg.sv */
// shared constants, types and helpers of the stable priority queue
`default_nettype none
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned LEVELS   = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned LVL_W    = $clog2(LEVELS);

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } link_req_t;

  // lowest set level, zero when none is set
  function automatic logic [LVL_W-1:0] first_level(input logic [LEVELS-1:0] ne);
    logic [LVL_W-1:0] idx;
    idx = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne[i]) idx = LVL_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

/* src/spq_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/spq_link_store.sv */
// link memory with per-slot written flags, unwritten slots read as the free chain
`default_nettype none
module spq_link_store (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire spq_pkg::link_req_t        req_i,
  output      logic [spq_pkg::SLOT_W-1:0] link_o
);

  logic [spq_pkg::CAPACITY-1:0] written_q;
  logic                         rd_written_q;
  logic [spq_pkg::SLOT_W-1:0]   raddr_q;
  logic [spq_pkg::SLOT_W-1:0]   ram_rdata;
  logic [spq_pkg::SLOT_W-1:0]   chain_next;

  spq_ram #(
    .WIDTH(spq_pkg::SLOT_W),
    .DEPTH(spq_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wdata),
    .re_i   (req_i.re),
    .raddr_i(req_i.raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
      raddr_q      <= '0;
    end else begin
      if (req_i.re) begin
        rd_written_q <= written_q[req_i.raddr];
        raddr_q      <= req_i.raddr;
      end
      if (req_i.we) written_q[req_i.waddr] <= 1'b1;
    end
  end

  // reset chain: slot i points at i+1, last slot wraps to zero
  assign chain_next = (raddr_q == spq_pkg::SLOT_W'(spq_pkg::CAPACITY - 1)) ? '0
                    : spq_pkg::SLOT_W'(raddr_q + 1'b1);
  assign link_o = rd_written_q ? ram_rdata : chain_next;

endmodule
`default_nettype wire

/* src/stable_priority_queue_ten_levels_core.sv */
// top level of the stable ten-level priority queue
// Stable priority queue, levels 0 (served first) to 9, 16 entries. Every input
// transfer (enqueue or dequeue) yields exactly one result transfer. An item
// passes from input transfer to result through the states IDLE (the transfer),
// EXEC (reads and writes the link and value memories), LINK (takes the link
// read back and reads the new head's value) and RESP (loads the output
// register, waiting while it is still held). The next input transfer is taken
// while a result waits there. The rate is set by the registered reads of the
// link and value memories, which are walked one after the other.
`default_nettype none
`include "stable_priority_queue_ten_levels_core_macros.svh"
module stable_priority_queue_ten_levels_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic                        action_i,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] value_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]  priority_req_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [1:0]                  status_o,
  output      logic signed [spq_pkg::VALUE_W-1:0] taken_value_o,
  output      logic                        head_valid_o,
  output      logic signed [spq_pkg::VALUE_W-1:0] head_value_o,
  output      logic [spq_pkg::PRIO_W-1:0]  head_priority_o,
  output      logic [spq_pkg::COUNT_W-1:0] occupancy_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_LINK = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic                         act_q;
  logic [spq_pkg::VALUE_W-1:0]  val_q;
  logic [spq_pkg::LVL_W-1:0]    lvl_q;
  logic [spq_pkg::SLOT_W-1:0]   level_head_q [spq_pkg::LEVELS];
  logic [spq_pkg::SLOT_W-1:0]   level_tail_q [spq_pkg::LEVELS];
  logic [spq_pkg::LEVELS-1:0]   nonempty_q;
  logic [spq_pkg::SLOT_W-1:0]   free_head_q;
  logic [spq_pkg::COUNT_W-1:0]  count_q;
  logic                         ok_q;
  logic                         last_q;
  logic [spq_pkg::LVL_W-1:0]    deq_lvl_q;
  spq_pkg::status_e             status_q;
  logic [spq_pkg::VALUE_W-1:0]  taken_q;
  logic                         hv_q;
  logic [spq_pkg::PRIO_W-1:0]   hp_q;

  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic [spq_pkg::VALUE_W-1:0]  out_taken_q;
  logic                         out_hv_q;
  logic [spq_pkg::VALUE_W-1:0]  out_hval_q;
  logic [spq_pkg::PRIO_W-1:0]   out_hp_q;
  logic [spq_pkg::COUNT_W-1:0]  out_count_q;

  logic                         in_xfer;
  logic                         out_free;
  logic                         full;
  logic                         any_ne;
  logic [spq_pkg::LVL_W-1:0]    low_lvl;
  logic [spq_pkg::SLOT_W-1:0]   link_next;
  logic [spq_pkg::SLOT_W-1:0]   head_addr;
  spq_pkg::link_req_t           link_req;
  logic                         val_we;
  logic [spq_pkg::SLOT_W-1:0]   val_waddr;
  logic                         val_re;
  logic [spq_pkg::SLOT_W-1:0]   val_raddr;
  logic [spq_pkg::VALUE_W-1:0]  val_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == spq_pkg::COUNT_W'(spq_pkg::CAPACITY));
  assign any_ne     = |nonempty_q;
  assign low_lvl    = spq_pkg::first_level(nonempty_q);

  // new head of the dequeued level is still in flight from the link memory
  assign head_addr = (act_q == spq_pkg::ACT_DEQ && ok_q && !last_q && low_lvl == deq_lvl_q)
                   ? link_next : level_head_q[low_lvl];

  spq_ram #(
    .WIDTH(spq_pkg::VALUE_W),
    .DEPTH(spq_pkg::CAPACITY)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_q),
    .re_i   (val_re),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  spq_link_store u_link (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (link_req),
    .link_o(link_next)
  );

  always_comb begin
    link_req  = '0;
    val_we    = 1'b0;
    val_waddr = free_head_q;
    val_re    = 1'b0;
    val_raddr = head_addr;
    state_d   = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (act_q == spq_pkg::ACT_ENQ) begin
          if (!full) begin
            val_we         = 1'b1;
            link_req.re    = 1'b1;
            link_req.raddr = free_head_q;
            link_req.we    = nonempty_q[lvl_q];
            link_req.waddr = level_tail_q[lvl_q];
            link_req.wdata = free_head_q;
          end
        end else if (any_ne) begin
          val_re         = 1'b1;
          val_raddr      = level_head_q[low_lvl];
          link_req.re    = 1'b1;
          link_req.raddr = level_head_q[low_lvl];
          link_req.we    = 1'b1;
          link_req.waddr = level_head_q[low_lvl];
          link_req.wdata = free_head_q;
        end
        state_d = ST_LINK;
      end
      ST_LINK: begin
        val_re  = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      act_q        <= spq_pkg::ACT_ENQ;
      val_q        <= '0;
      lvl_q        <= '0;
      for (int i = 0; i < spq_pkg::LEVELS; i++) begin
        level_head_q[i] <= '0;
        level_tail_q[i] <= '0;
      end
      nonempty_q   <= '0;
      free_head_q  <= '0;
      count_q      <= '0;
      ok_q         <= 1'b0;
      last_q       <= 1'b0;
      deq_lvl_q    <= '0;
      status_q     <= spq_pkg::STAT_OK;
      taken_q      <= '0;
      hv_q         <= 1'b0;
      hp_q         <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_taken_q  <= '0;
      out_hv_q     <= 1'b0;
      out_hval_q   <= '0;
      out_hp_q     <= '0;
      out_count_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && state_q != ST_RESP) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            act_q <= action_i;
            val_q <= value_i;
            // out-of-range levels fold into the last one
            lvl_q <= (int'(priority_req_i) >= spq_pkg::LEVELS)
                   ? spq_pkg::LVL_W'(spq_pkg::LEVELS - 1)
                   : spq_pkg::LVL_W'(priority_req_i);
          end
        end
        ST_EXEC: begin
          deq_lvl_q <= low_lvl;
          if (act_q == spq_pkg::ACT_ENQ) begin
            last_q <= 1'b0;
            if (full) begin
              ok_q     <= 1'b0;
              status_q <= spq_pkg::STAT_FULL;
            end else begin
              ok_q     <= 1'b1;
              status_q <= spq_pkg::STAT_OK;
              if (!nonempty_q[lvl_q]) begin
                level_head_q[lvl_q] <= free_head_q;
                nonempty_q[lvl_q]   <= 1'b1;
              end
              level_tail_q[lvl_q] <= free_head_q;
              count_q <= spq_pkg::COUNT_W'(count_q + 1'b1);
            end
          end else if (!any_ne) begin
            ok_q     <= 1'b0;
            last_q   <= 1'b0;
            status_q <= spq_pkg::STAT_EMPTY;
          end else begin
            ok_q        <= 1'b1;
            status_q    <= spq_pkg::STAT_OK;
            free_head_q <= level_head_q[low_lvl];
            last_q      <= (level_head_q[low_lvl] == level_tail_q[low_lvl]);
            if (level_head_q[low_lvl] == level_tail_q[low_lvl]) begin
              nonempty_q[low_lvl] <= 1'b0;
            end
            if (count_q != '0) count_q <= spq_pkg::COUNT_W'(count_q - 1'b1);
          end
        end
        ST_LINK: begin
          if (ok_q) begin
            if (act_q == spq_pkg::ACT_ENQ) begin
              free_head_q <= link_next;
            end else if (!last_q) begin
              level_head_q[deq_lvl_q] <= link_next;
            end
          end
          taken_q <= (act_q == spq_pkg::ACT_DEQ && ok_q) ? val_rdata : '0;
          hv_q    <= any_ne;
          hp_q    <= any_ne ? spq_pkg::PRIO_W'(low_lvl) : '0;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_taken_q  <= taken_q;
            out_hv_q     <= hv_q;
            out_hval_q   <= hv_q ? val_rdata : '0;
            out_hp_q     <= hp_q;
            out_count_q  <= count_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign taken_value_o   = out_taken_q;
  assign head_valid_o    = out_hv_q;
  assign head_value_o    = out_hval_q;
  assign head_priority_o = out_hp_q;
  assign occupancy_o     = out_count_q;

  `SPQ_ASSERT_NEVER(a_count_bound,
    count_q > spq_pkg::COUNT_W'(spq_pkg::CAPACITY), "count above capacity")
  `SPQ_ASSERT(a_levels_match_count,
    state_q == ST_IDLE |-> (any_ne == (count_q != '0)), "level flags disagree with count")
  `SPQ_ASSERT(a_head_flag,
    out_valid_q |-> (out_hv_q == (out_count_q != '0)), "head flag disagrees with occupancy")
  `SPQ_ASSERT(a_full_status,
    out_valid_q && out_status_q == spq_pkg::STAT_FULL
      |-> out_count_q == spq_pkg::COUNT_W'(spq_pkg::CAPACITY), "full reported below capacity")

endmodule
`default_nettype wire
